// ===== src/bres_pkg.sv =====
// Shared constants and octant lookup functions for the line rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package bres_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef logic [2:0] t_octant;

    localparam t_octant OCT1 = 3'd0;
    localparam t_octant OCT2 = 3'd1;
    localparam t_octant OCT3 = 3'd2;
    localparam t_octant OCT4 = 3'd3;
    localparam t_octant OCT5 = 3'd4;
    localparam t_octant OCT6 = 3'd5;
    localparam t_octant OCT7 = 3'd6;
    localparam t_octant OCT8 = 3'd7;

    // bit i belongs to octant code i
    localparam logic [7:0] MAJOR_IS_X    = 8'b1001_1001;
    localparam logic [7:0] MAJOR_NEG     = 8'b0111_1000;
    localparam logic [7:0] STRICT_TEST   = 8'b1110_0001;
    localparam logic [7:0] MINOR_ON_TRUE = 8'b1010_1010;
    localparam logic [7:0] MINOR_NEG     = 8'b1011_0100;

    function automatic logic f_major_is_x(input t_octant o);
        return MAJOR_IS_X[o];
    endfunction

    function automatic logic f_major_neg(input t_octant o);
        return MAJOR_NEG[o];
    endfunction

    function automatic logic f_strict(input t_octant o);
        return STRICT_TEST[o];
    endfunction

    function automatic logic f_minor_on_true(input t_octant o);
        return MINOR_ON_TRUE[o];
    endfunction

    function automatic logic f_minor_neg(input t_octant o);
        return MINOR_NEG[o];
    endfunction

endpackage
`default_nettype wire

// ===== src/bres_setup.sv =====
// Octant selection and decision-term setup for a new line.
`timescale 1ns / 1ps
`default_nettype none
module bres_setup
    import bres_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic signed [COORD_BITS-1:0] i_x0,
    input  wire logic signed [COORD_BITS-1:0] i_y0,
    input  wire logic signed [COORD_BITS-1:0] i_x1,
    input  wire logic signed [COORD_BITS-1:0] i_y1,
    output t_octant                           o_octant,
    output logic signed [COORD_BITS+3:0]      o_inc_a,
    output logic signed [COORD_BITS+3:0]      o_inc_b,
    output logic signed [COORD_BITS+3:0]      o_decision
);
    localparam int DW = COORD_BITS + 4;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] d2x;
    logic signed [DW-1:0] d2y;

    always_comb begin
        dx  = DW'(i_x1) - DW'(i_x0);
        dy  = DW'(i_y1) - DW'(i_y0);
        d2x = dx <<< 1;
        d2y = dy <<< 1;
        if (i_y1 > i_y0) begin
            if (i_x1 > i_x0) begin
                o_octant = (dy <= dx) ? OCT1 : OCT2;
            end else begin
                o_octant = (dx >= -dy) ? OCT3 : OCT4;
            end
        end else begin
            if (i_x1 < i_x0) begin
                o_octant = (dx <= dy) ? OCT5 : OCT6;
            end else begin
                o_octant = (dx <= -dy) ? OCT7 : OCT8;
            end
        end
        case (o_octant)
            OCT1: begin
                o_inc_a = d2y;        o_inc_b = d2y - d2x;  o_decision = d2y - dx;
            end
            OCT2: begin
                o_inc_a = d2y - d2x;  o_inc_b = -d2x;       o_decision = dy - d2x;
            end
            OCT3: begin
                o_inc_a = -d2x;       o_inc_b = -d2y - d2x; o_decision = -dy - d2x;
            end
            OCT4: begin
                o_inc_a = -d2y - d2x; o_inc_b = -d2y;       o_decision = -d2y - dx;
            end
            OCT5: begin
                o_inc_a = -d2y;       o_inc_b = d2x - d2y;  o_decision = dx - d2y;
            end
            OCT6: begin
                o_inc_a = d2x - d2y;  o_inc_b = d2x;        o_decision = d2x - dy;
            end
            OCT7: begin
                o_inc_a = d2x;        o_inc_b = d2y + d2x;  o_decision = dy + d2x;
            end
            default: begin
                o_inc_a = d2y + d2x;  o_inc_b = d2y;        o_decision = d2y + dx;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== src/bres_step.sv =====
// One Bresenham step: advance the major axis, test the decision term.
`timescale 1ns / 1ps
`default_nettype none
module bres_step
    import bres_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic signed [COORD_BITS-1:0] i_cur_x,
    input  wire logic signed [COORD_BITS-1:0] i_cur_y,
    input  wire logic signed [COORD_BITS+3:0] i_decision,
    input  wire logic signed [COORD_BITS+3:0] i_inc_a,
    input  wire logic signed [COORD_BITS+3:0] i_inc_b,
    input  wire t_octant                      i_octant,
    output logic signed [COORD_BITS-1:0]      o_next_x,
    output logic signed [COORD_BITS-1:0]      o_next_y,
    output logic signed [COORD_BITS+3:0]      o_next_decision
);
    localparam logic signed [COORD_BITS-1:0] ONE = COORD_BITS'(1);

    logic                         cond;
    logic                         move_minor;
    logic signed [COORD_BITS-1:0] major_step;
    logic signed [COORD_BITS-1:0] minor_step;

    always_comb begin
        cond = f_strict(i_octant) ? (i_decision < 0) : (i_decision <= 0);
        move_minor = (cond == f_minor_on_true(i_octant));
        major_step = f_major_neg(i_octant) ? -ONE : ONE;
        minor_step = move_minor ? (f_minor_neg(i_octant) ? -ONE : ONE) : '0;
        if (f_major_is_x(i_octant)) begin
            o_next_x = i_cur_x + major_step;
            o_next_y = i_cur_y + minor_step;
        end else begin
            o_next_x = i_cur_x + minor_step;
            o_next_y = i_cur_y + major_step;
        end
        o_next_decision = i_decision + (cond ? i_inc_a : i_inc_b);
    end
endmodule
`default_nettype wire

// ===== src/bresenham_line_rasterizer_top.sv =====
// Top level of the eight-octant line rasterizer with stream ports.
//
//  channel | dir | tdata (low bit up)                        | tuser  | tlast
//  s_axis  | in  | start_x, start_y, end_x, end_y             | action | -
//  m_axis  | out | pixel_x, pixel_y                          | -      | last
//
//  One word per ready cycle; each accepted word leaves its pixel in the output
//  register on the next cycle, and a tick with no line running yields none.
//  Line state and the output register update in the same single pass.
//  s_axis_tready is low only while a pixel waits and m_axis_tready is low.
//  Synchronous active-low reset drops the running line and the held pixel.
`timescale 1ns / 1ps
`default_nettype none
module bresenham_line_rasterizer_top
    import bres_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // start_x, start_y, end_x, end_y
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // action
    input  wire logic                                    s_axis_tuser,
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // pixel_x, pixel_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]            m_axis_tdata,
    output logic                                         m_axis_tlast
);
    localparam int C  = COORD_BITS;
    localparam int DW = COORD_BITS + 4;
    localparam int OW = ((2*COORD_BITS+7)/8)*8;

    logic signed [C-1:0]  in_x0, in_y0, in_x1, in_y1;
    t_octant              su_octant;
    logic signed [DW-1:0] su_inc_a, su_inc_b, su_dec;
    logic signed [C-1:0]  st_x, st_y;
    logic signed [DW-1:0] st_dec;

    logic signed [C-1:0]  r_cur_x, r_cur_y, r_goal_x, r_goal_y;
    logic signed [C-1:0]  n_cur_x, n_cur_y, n_goal_x, n_goal_y;
    logic signed [DW-1:0] r_dec, r_inc_a, r_inc_b;
    logic signed [DW-1:0] n_dec, n_inc_a, n_inc_b;
    t_octant              r_oct, n_oct;
    logic                 r_busy, n_busy;
    logic                 r_out_valid, n_out_valid;
    logic [OW-1:0]        r_out_data, n_out_data;
    logic                 r_out_last, n_out_last;
    logic                 accept;
    logic                 at_goal;

    assign in_x0 = s_axis_tdata[C-1:0];
    assign in_y0 = s_axis_tdata[2*C-1:C];
    assign in_x1 = s_axis_tdata[3*C-1:2*C];
    assign in_y1 = s_axis_tdata[4*C-1:3*C];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    bres_setup #(.COORD_BITS(COORD_BITS)) u_setup (
        .i_x0       (in_x0),
        .i_y0       (in_y0),
        .i_x1       (in_x1),
        .i_y1       (in_y1),
        .o_octant   (su_octant),
        .o_inc_a    (su_inc_a),
        .o_inc_b    (su_inc_b),
        .o_decision (su_dec)
    );

    bres_step #(.COORD_BITS(COORD_BITS)) u_step (
        .i_cur_x         (r_cur_x),
        .i_cur_y         (r_cur_y),
        .i_decision      (r_dec),
        .i_inc_a         (r_inc_a),
        .i_inc_b         (r_inc_b),
        .i_octant        (r_oct),
        .o_next_x        (st_x),
        .o_next_y        (st_y),
        .o_next_decision (st_dec)
    );

    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_goal_x    = r_goal_x;
        n_goal_y    = r_goal_y;
        n_dec       = r_dec;
        n_inc_a     = r_inc_a;
        n_inc_b     = r_inc_b;
        n_oct       = r_oct;
        n_busy      = r_busy;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        at_goal     = 1'b0;
        if (accept) begin
            n_out_valid = 1'b0;
            if (s_axis_tuser == ACT_START) begin
                n_cur_x  = in_x0;
                n_cur_y  = in_y0;
                n_goal_x = in_x1;
                n_goal_y = in_y1;
                n_dec    = su_dec;
                n_inc_a  = su_inc_a;
                n_inc_b  = su_inc_b;
                n_oct    = su_octant;
                n_out_valid = 1'b1;
            end else if (r_busy) begin
                n_cur_x = st_x;
                n_cur_y = st_y;
                n_dec   = st_dec;
                n_out_valid = 1'b1;
            end
            if (n_out_valid) begin
                at_goal = f_major_is_x(n_oct) ? (n_cur_x == n_goal_x)
                                              : (n_cur_y == n_goal_y);
                n_busy     = !at_goal;
                n_out_last = at_goal;
                n_out_data = '0;
                n_out_data[C-1:0]   = n_cur_x;
                n_out_data[2*C-1:C] = n_cur_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_cur_x    <= n_cur_x;
        r_cur_y    <= n_cur_y;
        r_goal_x   <= n_goal_x;
        r_goal_y   <= n_goal_y;
        r_dec      <= n_dec;
        r_inc_a    <= n_inc_a;
        r_inc_b    <= n_inc_b;
        r_oct      <= n_oct;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
endmodule
`default_nettype wire

// ===== src/bres_checker.sv =====
// Port-level checks for the line rasterizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bres_checker
    import bres_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input wire logic                              s_axis_tuser,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    input wire logic                              m_axis_tlast
);
    localparam int C = COORD_BITS;

    logic start_acc;
    assign start_acc = i_rst_n && s_axis_tvalid && s_axis_tready
                       && (s_axis_tuser == ACT_START);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("held pixel changed while stalled");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    a_start_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_acc |=> m_axis_tvalid
            && m_axis_tdata[C-1:0] == $past(s_axis_tdata[C-1:0])
            && m_axis_tdata[2*C-1:C] == $past(s_axis_tdata[2*C-1:C]))
        else $error("start word did not emit its first endpoint");

    a_point_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_acc && s_axis_tdata[C-1:0] == s_axis_tdata[3*C-1:2*C]
            && s_axis_tdata[2*C-1:C] == s_axis_tdata[4*C-1:3*C]
            |=> m_axis_tlast)
        else $error("zero-length line not marked last");
endmodule

bind bresenham_line_rasterizer_top bres_checker #(.COORD_BITS(COORD_BITS)) u_bres_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
